### design/fxalu_pkg.sv
// ----------------------------------------------------------------------------
// fxalu_pkg
// Shared types and codes for the signed fixed-point ALU.
// ----------------------------------------------------------------------------
package fxalu_pkg;

  localparam int FRAC_BITS_DEFAULT = 8;

  localparam logic [3:0] CMD_ADD    = 4'd0;
  localparam logic [3:0] CMD_SUB    = 4'd1;
  localparam logic [3:0] CMD_MUL    = 4'd2;
  localparam logic [3:0] CMD_DIV    = 4'd3;
  localparam logic [3:0] CMD_GT     = 4'd4;
  localparam logic [3:0] CMD_LT     = 4'd5;
  localparam logic [3:0] CMD_GE     = 4'd6;
  localparam logic [3:0] CMD_LE     = 4'd7;
  localparam logic [3:0] CMD_EQ     = 4'd8;
  localparam logic [3:0] CMD_NE     = 4'd9;
  localparam logic [3:0] CMD_INC    = 4'd10;
  localparam logic [3:0] CMD_DEC    = 4'd11;
  localparam logic [3:0] CMD_TO_INT = 4'd12;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  localparam logic [1:0] CLS_SIMPLE = 2'd0;
  localparam logic [1:0] CLS_MUL    = 2'd1;
  localparam logic [1:0] CLS_DIV    = 2'd2;

  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic        [3:0]  cmd;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic        [1:0]  status;
  } result_t;

  // per-item info carried alongside the divider chain
  typedef struct packed {
    logic [1:0]         cls;
    logic               neg;
    logic signed [31:0] sval;
    logic [1:0]         sst;
  } side_t;

endpackage

### design/fxalu_front.sv
// ----------------------------------------------------------------------------
// fxalu_front
// Decode, add/compare ops and magnitudes (stage A), then the magnitude
// product and divider setup (stage B).
// ----------------------------------------------------------------------------
module fxalu_front import fxalu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  item_t                          item,
  output logic                           valid,
  output side_t                          side,
  output logic [63:0]                    prod,
  output logic [32+FRAC_BITS-1:0]        num,
  output logic [31:0]                    den
);

  logic               a_valid;
  side_t              a_side;
  logic [31:0]        a_mag_a;
  logic [31:0]        a_mag_b;
  side_t              side_next;
  logic [31:0]        mag_a_next;
  logic [31:0]        mag_b_next;
  logic signed [32:0] sum;
  logic signed [32:0] dif;
  logic signed [32:0] incv;
  logic signed [32:0] decv;
  logic [31:0]        tint;
  logic signed [31:0] sa;
  logic signed [31:0] sb;

  always_comb begin
    sa = item.operand_a;
    sb = item.operand_b;
    mag_a_next = sa[31] ? 32'(-sa) : 32'(sa);
    mag_b_next = sb[31] ? 32'(-sb) : 32'(sb);
    sum  = {sa[31], sa} + {sb[31], sb};
    dif  = {sa[31], sa} - {sb[31], sb};
    incv = {sa[31], sa} + 33'sd1;
    decv = {sa[31], sa} - 33'sd1;
    tint = mag_a_next >> FRAC_BITS;
    side_next.cls  = CLS_SIMPLE;
    side_next.neg  = sa[31] ^ sb[31];
    side_next.sval = '0;
    side_next.sst  = ST_OK;
    unique case (item.cmd)
      CMD_ADD: begin
        side_next.sval = sum[32] != sum[31] ? (sum[32] ? VAL_MIN : VAL_MAX) : sum[31:0];
        side_next.sst  = sum[32] != sum[31] ? ST_OVF : ST_OK;
      end
      CMD_SUB: begin
        side_next.sval = dif[32] != dif[31] ? (dif[32] ? VAL_MIN : VAL_MAX) : dif[31:0];
        side_next.sst  = dif[32] != dif[31] ? ST_OVF : ST_OK;
      end
      CMD_MUL: side_next.cls = CLS_MUL;
      CMD_DIV: begin
        if (sb == 32'sd0) begin
          side_next.sst = ST_DZ;
        end else begin
          side_next.cls = CLS_DIV;
        end
      end
      CMD_GT: side_next.sval = {31'd0, sa > sb};
      CMD_LT: side_next.sval = {31'd0, sa < sb};
      CMD_GE: side_next.sval = {31'd0, sa >= sb};
      CMD_LE: side_next.sval = {31'd0, sa <= sb};
      CMD_EQ: side_next.sval = {31'd0, sa == sb};
      CMD_NE: side_next.sval = {31'd0, sa != sb};
      CMD_INC: begin
        side_next.sval = incv[32] != incv[31] ? VAL_MAX : incv[31:0];
        side_next.sst  = incv[32] != incv[31] ? ST_OVF : ST_OK;
      end
      CMD_DEC: begin
        side_next.sval = decv[32] != decv[31] ? VAL_MIN : decv[31:0];
        side_next.sst  = decv[32] != decv[31] ? ST_OVF : ST_OK;
      end
      CMD_TO_INT: side_next.sval = sa[31] ? 32'(-tint) : tint;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      valid   <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      valid   <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side  <= side_next;
      a_mag_a <= mag_a_next;
      a_mag_b <= mag_b_next;
      side    <= a_side;
      prod    <= 64'(a_mag_a) * 64'(a_mag_b);
      num     <= {a_mag_a, {FRAC_BITS{1'b0}}};
      den     <= a_mag_b;
    end
  end

endmodule

### design/fxalu_div_stage.sv
// ----------------------------------------------------------------------------
// fxalu_div_stage
// One restoring division step: brings down one numerator bit, produces one
// quotient bit. Also carries the item info and product forward.
// ----------------------------------------------------------------------------
module fxalu_div_stage import fxalu_pkg::*; #(
  parameter int NW = 32 + FRAC_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  side_t         in_side,
  input  logic [63:0]   in_prod,
  input  logic [NW-1:0] in_num,
  input  logic [NW-1:0] in_quo,
  input  logic [31:0]   in_rem,
  input  logic [31:0]   in_den,
  output logic          valid,
  output side_t         side,
  output logic [63:0]   prod,
  output logic [NW-1:0] num,
  output logic [NW-1:0] quo,
  output logic [31:0]   rem,
  output logic [31:0]   den
);

  logic [32:0] trial;
  logic        fits;

  assign trial = {in_rem, in_num[NW-1]};
  assign fits  = trial >= {1'b0, in_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side <= in_side;
      prod <= in_prod;
      num  <= {in_num[NW-2:0], 1'b0};
      quo  <= {in_quo[NW-2:0], fits};
      rem  <= fits ? 32'(trial - {1'b0, in_den}) : trial[31:0];
      den  <= in_den;
    end
  end

endmodule

### design/fxalu_back.sv
// ----------------------------------------------------------------------------
// fxalu_back
// Rounding, sign and saturation of product and quotient; output register.
// ----------------------------------------------------------------------------
module fxalu_back import fxalu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  side_t                   in_side,
  input  logic [63:0]             in_prod,
  input  logic [32+FRAC_BITS-1:0] in_quo,
  input  logic [31:0]             in_rem,
  input  logic [31:0]             in_den,
  output logic                    valid,
  output result_t                 result
);

  localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

  logic [63:0] mq;
  logic [63:0] dq;
  logic [63:0] mag;
  result_t     res_next;

  always_comb begin
    mq  = (in_prod + HALF) >> FRAC_BITS;
    dq  = 64'(in_quo) + 64'({in_rem, 1'b0} >= {1'b0, in_den});
    mag = (in_side.cls == CLS_MUL) ? mq : dq;
    res_next.value  = in_side.sval;
    res_next.status = in_side.sst;
    if (in_side.cls != CLS_SIMPLE) begin
      res_next.status = ST_OK;
      if (in_side.neg) begin
        if (mag > 64'h8000_0000) begin
          res_next.value  = VAL_MIN;
          res_next.status = ST_OVF;
        end else begin
          res_next.value = 32'(-mag[31:0]);
        end
      end else begin
        if (mag > 64'h7fff_ffff) begin
          res_next.value  = VAL_MAX;
          res_next.status = ST_OVF;
        end else begin
          res_next.value = mag[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= res_next;
    end
  end

endmodule

### design/fixed_point_q24_8_alu_unit.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_unit
// Signed fixed-point ALU, pipelined.
// ----------------------------------------------------------------------------
// Takes one item per cycle unless the output is stalled, and returns one result
// per item, in order. Every item passes through two front stages (decode and
// magnitudes, then the 32x32 product), one stage per quotient bit of the
// restoring divider (32 + FRAC_BITS), and the rounding and saturation stage
// that is also the output register. A stalled output holds the whole
// pipeline.
module fixed_point_q24_8_alu_unit import fxalu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int NW = 32 + FRAC_BITS;

  logic en;
  assign en         = !(result_valid && result_stall);
  assign item_stall = result_valid && result_stall;

  logic          v    [0:NW];
  side_t         sd   [0:NW];
  logic [63:0]   pr   [0:NW];
  logic [NW-1:0] nm   [0:NW];
  logic [NW-1:0] qu   [0:NW];
  logic [31:0]   rm   [0:NW];
  logic [31:0]   dn   [0:NW];

  fxalu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(item_valid), .item(item),
    .valid(v[0]), .side(sd[0]), .prod(pr[0]), .num(nm[0]), .den(dn[0])
  );

  assign qu[0] = '0;
  assign rm[0] = '0;

  for (genvar i = 0; i < NW; i++) begin : g_div
    fxalu_div_stage #(.NW(NW)) u_stage (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(v[i]), .in_side(sd[i]), .in_prod(pr[i]), .in_num(nm[i]),
      .in_quo(qu[i]), .in_rem(rm[i]), .in_den(dn[i]),
      .valid(v[i+1]), .side(sd[i+1]), .prod(pr[i+1]), .num(nm[i+1]),
      .quo(qu[i+1]), .rem(rm[i+1]), .den(dn[i+1])
    );
  end

  fxalu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .en(en), .in_valid(v[NW]), .in_side(sd[NW]),
    .in_prod(pr[NW]), .in_quo(qu[NW]), .in_rem(rm[NW]), .in_den(dn[NW]),
    .valid(result_valid), .result(result)
  );

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_DZ |-> result.value == 32'sd0)
    else $error("division by zero result is not zero");

  a_ovf_rail: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_OVF |->
      result.value == VAL_MAX || result.value == VAL_MIN)
    else $error("overflow result not saturated");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status != 2'd3)
    else $error("undefined status code");

endmodule
